// File: rtl/aesd_pkg.sv
// Shared types and command codes for the AES-128 inverse cipher block.
`default_nettype none
package aesd_pkg;

   localparam int unsigned HALF_W  = 64;
   localparam int unsigned BLOCK_W = 128;
   localparam int unsigned INDEX_W = 5;

   typedef struct packed {
      logic               mode;
      logic [INDEX_W-1:0] index;
      logic [HALF_W-1:0]  payload;
   } req_type;

   typedef struct packed {
      logic [HALF_W-1:0] plain_half;
      logic              last;
   } rsp_type;

   typedef enum logic {
      CMD_KEY = 1'b0,
      CMD_DEC = 1'b1
   } cmd_kind_type;

   localparam logic MODE_KEY    = 1'b0;
   localparam logic MODE_CIPHER = 1'b1;

   localparam logic [INDEX_W-1:0] CIPHER_FIRST  = 5'd0;
   localparam logic [INDEX_W-1:0] CIPHER_SECOND = 5'd1;

   // One queued unit of work: a key half write or a full ciphertext block.
   typedef struct packed {
      cmd_kind_type       kind;
      logic [INDEX_W-1:0] index;
      logic [BLOCK_W-1:0] data;
   } cmd_type;

endpackage
`default_nettype wire

// File: rtl/aes_block_decrypt_core.sv
// Top level of the AES-128 inverse cipher: front end, command queue, round engine.
//
//  channel | ports                         | moves
//  --------+-------------------------------+-----------------------------------
//  request | req_valid, req_ready, req_data | key half or ciphertext half
//  result  | rsp_valid, rsp_ready, rsp_data | plaintext half, last flag
//
// A key write goes to the engine's key store; a first ciphertext half stays in the front end.
// In the engine a block goes through queue pop, key addition, one inverse round per cycle
// in the shared round unit, and two result transfers.
// The request side keeps taking transfers into a two-entry queue during that.
// Reset is synchronous; the key store is not cleared and must be loaded first.
// A stalled result holds the engine; the queue then fills and req_ready drops.
`default_nettype none
module aes_block_decrypt_core
   import aesd_pkg::*;
#(
   parameter int unsigned NUM_ROUNDS = 10
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   logic    f_valid, f_ready;
   cmd_type f_cmd;
   logic    q_valid, q_ready;
   cmd_type q_cmd;

   aesd_front #(.NUM_ROUNDS(NUM_ROUNDS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cmd_valid (f_valid),
      .cmd_ready (f_ready),
      .cmd_data  (f_cmd)
   );

   aesd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_data  (f_cmd),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_data   (q_cmd)
   );

   aesd_engine #(.NUM_ROUNDS(NUM_ROUNDS)) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q_valid),
      .cmd_ready (q_ready),
      .cmd_data  (q_cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

// File: rtl/aesd_front.sv
// Front end: accepts request transfers, holds the first ciphertext half, issues commands.
`default_nettype none
module aesd_front
   import aesd_pkg::*;
#(
   parameter int unsigned NUM_ROUNDS = 10
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         cmd_valid,
   input  wire logic    cmd_ready,
   output cmd_type      cmd_data
);

   localparam int unsigned KeySlots = 2 * (NUM_ROUNDS + 1);

   logic [HALF_W-1:0] held_ff, held_in;
   logic              take;

   assign req_ready = cmd_ready;
   assign take      = req_valid && cmd_ready;

   always_comb begin
      held_in       = held_ff;
      cmd_valid     = 1'b0;
      cmd_data.kind = CMD_KEY;
      cmd_data.index = req_data.index;
      cmd_data.data = {held_ff, req_data.payload};
      if (req_data.mode == MODE_KEY) begin
         cmd_data.data = {{HALF_W{1'b0}}, req_data.payload};
         if (32'(req_data.index) < KeySlots) begin
            cmd_valid = req_valid;
         end
      end else if (req_data.index == CIPHER_FIRST) begin
         if (take) begin
            held_in = req_data.payload;
         end
      end else if (req_data.index == CIPHER_SECOND) begin
         cmd_data.kind = CMD_DEC;
         cmd_valid     = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else begin
         held_ff <= held_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/aesd_queue.sv
// Two-entry command queue between the front end and the round engine.
`default_nettype none
module aesd_queue
   import aesd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push_valid,
   output logic         push_ready,
   input  wire cmd_type push_data,
   output logic         pop_valid,
   input  wire logic    pop_ready,
   output cmd_type      pop_data
);

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/aesd_engine.sv
// Round engine: round-key store, one inverse round per cycle, plaintext output.
`default_nettype none
module aesd_engine
   import aesd_pkg::*;
#(
   parameter int unsigned NUM_ROUNDS = 10
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    cmd_valid,
   output logic         cmd_ready,
   input  wire cmd_type cmd_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   localparam int unsigned Depth = NUM_ROUNDS + 1;
   localparam int unsigned RW    = $clog2(Depth);

   localparam logic [7:0] INV_SBOX [256] = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_ROUND,
      ST_OUT0,
      ST_OUT1
   } state_type;

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // Byte k of the block sits at bits [127-8k -: 8].
   function automatic logic [BLOCK_W-1:0] unshift_unsub(input logic [BLOCK_W-1:0] b);
      logic [BLOCK_W-1:0] o;
      int unsigned        src;
      o = '0;
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            src = r + 4 * ((c + 4 - r) % 4);
            o[127 - 8 * (r + 4 * c) -: 8] = INV_SBOX[b[127 - 8 * src -: 8]];
         end
      end
      return o;
   endfunction

   function automatic logic [BLOCK_W-1:0] unmix(input logic [BLOCK_W-1:0] b);
      logic [BLOCK_W-1:0] o;
      logic [7:0]         s [4];
      logic [7:0]         s2 [4];
      logic [7:0]         s4 [4];
      logic [7:0]         s8 [4];
      logic [7:0]         m9, mb, md, me;
      o = '0;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            s[r]  = b[127 - 8 * (4 * c + r) -: 8];
            s2[r] = xtime(s[r]);
            s4[r] = xtime(s2[r]);
            s8[r] = xtime(s4[r]);
         end
         for (int r = 0; r < 4; r++) begin
            me = s8[r] ^ s4[r] ^ s2[r];
            mb = s8[(r + 1) % 4] ^ s2[(r + 1) % 4] ^ s[(r + 1) % 4];
            md = s8[(r + 2) % 4] ^ s4[(r + 2) % 4] ^ s[(r + 2) % 4];
            m9 = s8[(r + 3) % 4] ^ s[(r + 3) % 4];
            o[127 - 8 * (4 * c + r) -: 8] = me ^ mb ^ md ^ m9;
         end
      end
      return o;
   endfunction

   logic [HALF_W-1:0]  key_hi_mem [Depth];
   logic [HALF_W-1:0]  key_lo_mem [Depth];
   logic [HALF_W-1:0]  key_hi_ff, key_lo_ff;
   logic [RW-1:0]      addr_in;
   logic [RW-1:0]      wr_addr;
   logic               key_wr;

   state_type          state_ff, state_in;
   logic [RW-1:0]      rnd_ff, rnd_in;
   logic [BLOCK_W-1:0] blk_ff, blk_in;
   logic [BLOCK_W-1:0] keyed;

   assign cmd_ready = (state_ff == ST_IDLE);
   assign key_wr    = cmd_ready && cmd_valid && (cmd_data.kind == CMD_KEY);
   assign wr_addr   = RW'(cmd_data.index >> 1);
   assign keyed     = unshift_unsub(blk_ff) ^ {key_hi_ff, key_lo_ff};

   always_comb begin
      state_in = state_ff;
      rnd_in   = rnd_ff;
      blk_in   = blk_ff;
      addr_in  = '0;
      unique case (state_ff)
         ST_IDLE: begin
            addr_in = RW'(NUM_ROUNDS);
            if (cmd_valid && cmd_data.kind == CMD_DEC) begin
               blk_in   = cmd_data.data;
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            blk_in   = blk_ff ^ {key_hi_ff, key_lo_ff};
            rnd_in   = RW'(NUM_ROUNDS - 1);
            addr_in  = RW'(NUM_ROUNDS - 1);
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            if (rnd_ff == '0) begin
               // final round: no column mix
               blk_in   = keyed;
               state_in = ST_OUT0;
            end else begin
               blk_in  = unmix(keyed);
               rnd_in  = rnd_ff - 1'b1;
               addr_in = rnd_ff - 1'b1;
            end
         end
         ST_OUT0: begin
            if (rsp_ready) begin
               state_in = ST_OUT1;
            end
         end
         ST_OUT1: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (key_wr) begin
         if (cmd_data.index[0]) begin
            key_lo_mem[wr_addr] <= cmd_data.data[HALF_W-1:0];
         end else begin
            key_hi_mem[wr_addr] <= cmd_data.data[HALF_W-1:0];
         end
      end
      key_hi_ff <= key_hi_mem[addr_in];
      key_lo_ff <= key_lo_mem[addr_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rnd_ff   <= '0;
      end else begin
         state_ff <= state_in;
         rnd_ff   <= rnd_in;
      end
      blk_ff <= blk_in;
   end

   assign rsp_valid           = (state_ff == ST_OUT0) || (state_ff == ST_OUT1);
   assign rsp_data.last       = (state_ff == ST_OUT1);
   assign rsp_data.plain_half = (state_ff == ST_OUT1) ? blk_ff[HALF_W-1:0]
                                                      : blk_ff[BLOCK_W-1:HALF_W];

endmodule
`default_nettype wire

// File: rtl/aesd_checker.sv
// Port-level checks for the AES inverse cipher top level, with its bind.
`default_nettype none
module aesd_checker
   import aesd_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);

   logic rsp_xfer;
   assign rsp_xfer = rsp_valid && rsp_ready;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_second_half: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && !rsp_data.last |=> rsp_valid && rsp_data.last)
      else $error("second plaintext half did not follow the first");

   a_gap_after_block: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && rsp_data.last |=> !rsp_valid)
      else $error("result shown right after the last half of a block");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not empty after reset");

endmodule

bind aes_block_decrypt_core aesd_checker u_aesd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
`default_nettype wire

// File: tb/sv/aes_block_decrypt_core_tb.sv
// Testbench for the AES-128 inverse cipher block: directed and random traffic with a scoreboard.
`timescale 1ns / 1ps
`default_nettype none
module aes_block_decrypt_core_tb;
   import aesd_pkg::*;

   localparam int unsigned ROUNDS    = 10;
   localparam int unsigned KEY_SLOTS = 2 * (ROUNDS + 1);
   localparam int unsigned WATCHDOG  = 20000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   aes_block_decrypt_core #(.NUM_ROUNDS(ROUNDS)) u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #6 clock = ~clock;

   // predictor state
   logic [HALF_W-1:0] key_store [KEY_SLOTS];
   logic [HALF_W-1:0] held_half;
   rsp_type           plain_q [$];

   int  fail_count = 0;
   int  rsp_count = 0;
   int  req_count = 0;
   int  block_count = 0;
   int  idle_cycles = 0;
   bit  rsp_hold = 1'b0;
   bit  rsp_no_stall = 1'b0;
   bit  send_no_gap = 1'b0;

   logic [7:0] inv_sbox [256];

   function automatic logic [7:0] xtime(logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
      logic [7:0] acc;
      acc = '0;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) acc ^= a;
         a = xtime(a);
      end
      return acc;
   endfunction

   function automatic logic [127:0] xor_round_key(logic [127:0] blk, int unsigned rnd);
      return blk ^ {key_store[2 * rnd], key_store[2 * rnd + 1]};
   endfunction

   // byte k sits at bits [127-8k -: 8]
   function automatic logic [127:0] inv_shift_sub(logic [127:0] blk);
      logic [127:0] res;
      for (int r = 0; r < 4; r++)
         for (int c = 0; c < 4; c++)
            res[127 - 8 * (r + 4 * c) -: 8] =
               inv_sbox[blk[127 - 8 * (r + 4 * ((c + 4 - r) % 4)) -: 8]];
      return res;
   endfunction

   function automatic logic [127:0] inv_mix(logic [127:0] blk);
      logic [127:0] res;
      logic [7:0]   s [4];
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) s[r] = blk[127 - 8 * (4 * c + r) -: 8];
         for (int r = 0; r < 4; r++)
            res[127 - 8 * (4 * c + r) -: 8] = gmul(s[r], 8'h0e) ^
               gmul(s[(r + 1) % 4], 8'h0b) ^ gmul(s[(r + 2) % 4], 8'h0d) ^
               gmul(s[(r + 3) % 4], 8'h09);
      end
      return res;
   endfunction

   function automatic logic [127:0] decrypt_block(logic [127:0] cipher);
      logic [127:0] blk;
      blk = xor_round_key(cipher, ROUNDS);
      for (int rnd = ROUNDS - 1; rnd >= 1; rnd--)
         blk = inv_mix(xor_round_key(inv_shift_sub(blk), rnd));
      return xor_round_key(inv_shift_sub(blk), 0);
   endfunction

   task automatic predict_plain(req_type req);
      logic [127:0] plain;
      rsp_type      item;
      if (req.mode == MODE_KEY) begin
         if (req.index < KEY_SLOTS) key_store[req.index] = req.payload;
      end else if (req.index == CIPHER_FIRST) begin
         held_half = req.payload;
      end else if (req.index == CIPHER_SECOND) begin
         plain = decrypt_block({held_half, req.payload});
         item.plain_half = plain[127:64]; item.last = 1'b0; plain_q.push_back(item);
         item.plain_half = plain[63:0];   item.last = 1'b1; plain_q.push_back(item);
         block_count++;
      end
   endtask

   function automatic int gap_len();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
   endfunction

   // send one item; predictor runs at the transfer; valid drops only before a gap
   task automatic send_item(logic mode, logic [INDEX_W-1:0] idx, logic [HALF_W-1:0] data);
      int gap;
      gap = send_no_gap ? 0 : gap_len();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{mode: mode, index: idx, payload: data};
      do @(posedge clock); while (!req_ready);
      predict_plain(req_data);
      req_count++;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   task automatic load_schedule();
      for (int i = 0; i < KEY_SLOTS; i++) send_item(MODE_KEY, i[4:0], rand64());
   endtask

   task automatic send_block(logic [63:0] hi, logic [63:0] lo);
      send_item(MODE_CIPHER, CIPHER_FIRST, hi);
      send_item(MODE_CIPHER, CIPHER_SECOND, lo);
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (plain_q.size() != 0) @(posedge clock);
      repeat (ROUNDS + 8) @(posedge clock);
   endtask

   // result side: random stalls, a forced long hold-off on request
   initial begin
      int stall;
      @(negedge reset);
      forever begin
         if (rsp_hold) begin
            rsp_ready <= 1'b0;
            repeat (200) @(posedge clock);
            rsp_hold = 1'b0;
         end
         stall = rsp_no_stall ? 0 : gap_len();
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
      end
   end

   // check each result transfer against the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_count++;
         if (plain_q.size() == 0) begin
            $error("unexpected result plain_half=%h last=%b", rsp_data.plain_half, rsp_data.last);
            fail_count++;
         end else begin
            want = plain_q.pop_front();
            if (rsp_data.plain_half !== want.plain_half) begin
               $error("plain_half expected %h actual %h", want.plain_half, rsp_data.plain_half);
               fail_count++;
            end
            if (rsp_data.last !== want.last) begin
               $error("last expected %b actual %b", want.last, rsp_data.last);
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic test_known_vector();
      // FIPS-197 C.1 round keys, expected plaintext 00112233..ff
      logic [127:0] rk [11];
      rk[0]  = 128'h000102030405060708090a0b0c0d0e0f;
      rk[1]  = 128'hd6aa74fdd2af72fadaa678f1d6ab76fe;
      rk[2]  = 128'hb692cf0b643dbdf1be9bc5006830b3fe;
      rk[3]  = 128'hb6ff744ed2c2c9bf6c590cbf0469bf41;
      rk[4]  = 128'h47f7f7bc95353e03f96c32bcfd058dfd;
      rk[5]  = 128'h3caaa3e8a99f9deb50f3af57adf622aa;
      rk[6]  = 128'h5e390f7df7a69296a7553dc10aa31f6b;
      rk[7]  = 128'h14f9701ae35fe28c440adf4d4ea9c026;
      rk[8]  = 128'h47438735a41c65b9e016baf4aebf7ad2;
      rk[9]  = 128'h549932d1f08557681093ed9cbe2c974e;
      rk[10] = 128'h13111d7fe3944a17f307a78b4d2b30c5;
      for (int r = 0; r <= 10; r++) begin
         send_item(MODE_KEY, 5'(2 * r), rk[r][127:64]);
         send_item(MODE_KEY, 5'(2 * r + 1), rk[r][63:0]);
      end
      send_block(64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
      wait_drain();
      if (decrypt_block(128'h69c4e0d86a7b0430d8cdb78070b4c55a) !==
          128'h00112233445566778899aabbccddeeff) begin
         $error("plain_half expected %h actual predictor mismatch",
                128'h00112233445566778899aabbccddeeff);
         fail_count++;
      end
   endtask

   task automatic test_edges();
      send_block('0, '0);
      send_block('1, '1);
      send_item(MODE_CIPHER, CIPHER_SECOND, 64'h0123456789abcdef); // reuses held half
      send_item(MODE_KEY, 5'd22, '1);                              // out of range key
      send_item(MODE_KEY, 5'd31, '0);
      send_item(MODE_CIPHER, 5'd2, '1);                            // ignored cipher index
      send_item(MODE_CIPHER, 5'd31, 64'h5555aaaa5555aaaa);
      send_item(MODE_KEY, 5'd21, '0);
      send_item(MODE_KEY, 5'd0, '1);
      send_block(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
      wait_drain();
   endtask

   task automatic test_backpressure();
      rsp_hold = 1'b1;
      send_no_gap = 1'b1;
      for (int i = 0; i < 6; i++) send_block(rand64(), rand64());
      send_no_gap = 1'b0;
      wait_drain();
   endtask

   task automatic test_random(int n);
      int unsigned sel;
      while (n > 0) begin
         sel = $urandom_range(0, 19);
         if (sel == 0) begin
            load_schedule(); n -= KEY_SLOTS;
         end else if (sel < 3) begin
            send_item(1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)), rand64()); n--;
         end else if (sel == 3) begin
            rsp_no_stall = 1'b1; send_no_gap = 1'b1;
            send_block(rand64(), rand64()); n -= 2;
            rsp_no_stall = 1'b0; send_no_gap = 1'b0;
         end else begin
            send_block(rand64(), rand64()); n -= 2;
         end
      end
      wait_drain();
   endtask

   initial begin
      for (int i = 0; i < 256; i++) inv_sbox[i] = '0;
      inv_sbox = '{
 8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
 8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
 8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
 8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
 8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
 8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
 8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
 8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
 8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
 8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
 8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
 8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
 8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
 8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
 8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
 8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
      for (int i = 0; i < KEY_SLOTS; i++) key_store[i] = '0;
      held_half = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_known_vector();
      // lone second half reuses the held first half
      send_item(MODE_CIPHER, CIPHER_SECOND, rand64());
      test_edges();
      test_backpressure();
      test_random(1000);
      $display("covered %0d request transfers, %0d blocks decrypted, %0d results checked",
               req_count, block_count, rsp_count);
      if (fail_count == 0 && plain_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
`default_nettype wire

// File: files.f
rtl/aesd_pkg.sv
rtl/aesd_front.sv
rtl/aesd_queue.sv
rtl/aesd_engine.sv
rtl/aes_block_decrypt_core.sv
rtl/aesd_checker.sv
tb/sv/aes_block_decrypt_core_tb.sv
